[rtl/decimal_signed_add_sub_shift_top_macros.svh]
// assertion macros for the decimal add/sub/shift checker
// used only by dsas_chk.sv, no other dependencies
`ifndef DECIMAL_SIGNED_ADD_SUB_SHIFT_TOP_MACROS_SVH
`define DECIMAL_SIGNED_ADD_SUB_SHIFT_TOP_MACROS_SVH

// generic clocked assertion with active-low reset
`define DSAS_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dsas check failed");

// same on the block clock and reset
`define DSAS_CHECK(name, prop) \
  `DSAS_ASSERT(name, clk_i, rst_ni, prop)

`endif

[rtl/dsas_pkg.sv]
// package for the decimal add/sub/shift unit: sizes, codes, stage types
// and the bcd helper functions; no dependencies
package dsas_pkg;

  localparam int DIGITS = 47;
  localparam int DW     = 4 * DIGITS;
  localparam int IN_W   = 188;

  typedef logic [DW-1:0] digits_t;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_SUB   = 2'd1,
    CMD_MUL10 = 2'd2,
    CMD_DIV10 = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_POS_OVF = 2'd1,
    ERR_NEG_OVF = 2'd2,
    ERR_SHIFT   = 2'd3
  } err_e;

  typedef struct packed {
    logic    arith;
    logic    sa;
    logic    sb;
    logic    shift_sign;
    logic    shift_err;
    digits_t x;
    digits_t y;
  } s1_t;

  typedef struct packed {
    logic    neg;
    logic    sign;
    err_e    err;
    digits_t r;
  } s2_t;

  function automatic digits_t clamp_digits(logic [IN_W-1:0] w);
    digits_t    d;
    logic [3:0] v;
    for (int k = 0; k < DIGITS; k++) begin
      v = w[4*k +: 4];
      d[4*k +: 4] = (v > 4'd9) ? 4'd9 : v;
    end
    return d;
  endfunction

  // ten's complement of a magnitude, zero stays zero
  function automatic digits_t tens_comp(digits_t d);
    logic [DIGITS-1:0] nz;
    logic [DIGITS-1:0] low;
    logic [DIGITS-1:0] above;
    digits_t           t;
    logic [3:0]        v;
    for (int k = 0; k < DIGITS; k++) begin
      nz[k] = |d[4*k +: 4];
    end
    low   = nz & (~nz + DIGITS'(1));
    above = ~(low | (low - DIGITS'(1)));
    for (int k = 0; k < DIGITS; k++) begin
      v = d[4*k +: 4];
      if (above[k]) begin
        t[4*k +: 4] = 4'd9 - v;
      end else if (low[k]) begin
        t[4*k +: 4] = 4'd10 - v;
      end else begin
        t[4*k +: 4] = 4'd0;
      end
    end
    return t;
  endfunction

endpackage

[rtl/decimal_signed_add_sub_shift_top.sv]
// top level of the decimal add/sub/shift unit on sign-magnitude bcd numbers
// depends on dsas_pkg, dsas_prep, dsas_add, dsas_fix
//
// usage:
//   a request is taken at a rising edge with start high and busy low;
//   busy is always low, so a request may be issued every cycle
//   command_i: add, subtract a minus b, multiply a by ten, divide a by ten
//   operands come as sign plus 47 bcd digits split over low/mid/high words;
//   nibbles above 9 read as 9
//   the result shows for one cycle with result_valid_o high, once its request
//   has passed the prep, add and fix registers, in request order
//   throughput is one request per cycle; the stages that a request passes are
//   complement, carry-lookahead add, recomplement
//   error_code_o: positive overflow, negative overflow or lost top digit;
//   on error the sign and digits read zero
//   the receiver cannot stall; it must take each result in its cycle
//   reset clears the stage valid bits, results in flight are dropped
module decimal_signed_add_sub_shift_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic        a_sign_i,
  input  logic [63:0] a_digits_low_i,
  input  logic [63:0] a_digits_mid_i,
  input  logic [59:0] a_digits_high_i,
  input  logic        b_sign_i,
  input  logic [63:0] b_digits_low_i,
  input  logic [63:0] b_digits_mid_i,
  input  logic [59:0] b_digits_high_i,
  output logic        result_valid_o,
  output logic        result_sign_o,
  output logic [63:0] result_digits_low_o,
  output logic [63:0] result_digits_mid_o,
  output logic [59:0] result_digits_high_o,
  output logic [1:0]  error_code_o
);

  logic                      req;
  logic                      s1_valid;
  dsas_pkg::s1_t             s1;
  logic                      s2_valid;
  dsas_pkg::s2_t             s2;
  dsas_pkg::digits_t         res_digits;
  logic [dsas_pkg::IN_W-1:0] res_word;

  assign busy = 1'b0;
  assign req  = start & ~busy;

  dsas_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (req),
    .command_i  (command_i),
    .a_sign_i   (a_sign_i),
    .a_digits_i ({a_digits_high_i, a_digits_mid_i, a_digits_low_i}),
    .b_sign_i   (b_sign_i),
    .b_digits_i ({b_digits_high_i, b_digits_mid_i, b_digits_low_i}),
    .valid_o    (s1_valid),
    .s1_o       (s1)
  );

  dsas_add u_add (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .s1_i    (s1),
    .valid_o (s2_valid),
    .s2_o    (s2)
  );

  dsas_fix u_fix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s2_valid),
    .s2_i     (s2),
    .valid_o  (result_valid_o),
    .sign_o   (result_sign_o),
    .digits_o (res_digits),
    .err_o    (error_code_o)
  );

  assign res_word             = dsas_pkg::IN_W'(res_digits);
  assign result_digits_low_o  = res_word[63:0];
  assign result_digits_mid_o  = res_word[127:64];
  assign result_digits_high_o = res_word[187:128];

endmodule

[rtl/dsas_prep.sv]
// first stage: digit clamp, ten's complement of negative operands, shifts
// depends on dsas_pkg
module dsas_prep (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [1:0]                 command_i,
  input  logic                       a_sign_i,
  input  logic [dsas_pkg::IN_W-1:0]  a_digits_i,
  input  logic                       b_sign_i,
  input  logic [dsas_pkg::IN_W-1:0]  b_digits_i,
  output logic                       valid_o,
  output dsas_pkg::s1_t              s1_o
);

  dsas_pkg::digits_t a;
  dsas_pkg::digits_t b;
  logic              b_neg;
  dsas_pkg::s1_t     s1_d;
  dsas_pkg::s1_t     s1_q;
  logic              valid_q;

  assign a = dsas_pkg::clamp_digits(a_digits_i);
  assign b = dsas_pkg::clamp_digits(b_digits_i);

  always_comb begin
    b_neg           = b_sign_i;
    s1_d.arith      = 1'b0;
    s1_d.sa         = 1'b0;
    s1_d.sb         = 1'b0;
    s1_d.shift_sign = a_sign_i;
    s1_d.shift_err  = 1'b0;
    s1_d.x          = '0;
    s1_d.y          = '0;
    unique case (command_i) inside
      dsas_pkg::CMD_ADD, dsas_pkg::CMD_SUB: begin
        if (command_i == dsas_pkg::CMD_SUB) begin
          b_neg = ~b_sign_i;
        end
        s1_d.arith = 1'b1;
        s1_d.sa    = a_sign_i & (|a);
        s1_d.sb    = b_neg & (|b);
        s1_d.x     = a_sign_i ? dsas_pkg::tens_comp(a) : a;
        s1_d.y     = b_neg ? dsas_pkg::tens_comp(b) : b;
      end
      dsas_pkg::CMD_MUL10: begin
        if (a[dsas_pkg::DW-1 -: 4] != 4'd0) begin
          s1_d.shift_err  = 1'b1;
          s1_d.shift_sign = 1'b0;
        end else begin
          s1_d.x = {a[dsas_pkg::DW-5:0], 4'd0};
        end
      end
      dsas_pkg::CMD_DIV10: begin
        s1_d.x = {4'd0, a[dsas_pkg::DW-1:4]};
      end
      default: begin
        s1_d.x = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      s1_q <= s1_d;
    end
  end

  assign valid_o = valid_q;
  assign s1_o    = s1_q;

endmodule

[rtl/dsas_add.sv]
// second stage: bcd add with lookahead carry, sign fold and overflow check
// depends on dsas_pkg
module dsas_add (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  dsas_pkg::s1_t s1_i,
  output logic          valid_o,
  output dsas_pkg::s2_t s2_o
);

  logic [4:0]                  v [dsas_pkg::DIGITS];
  logic [dsas_pkg::DIGITS-1:0] gen;
  logic [dsas_pkg::DIGITS-1:0] gp;
  logic [dsas_pkg::DIGITS:0]   csum;
  logic [dsas_pkg::DIGITS-1:0] cin;
  logic                        cout;
  logic [4:0]                  u;
  dsas_pkg::digits_t           r;
  logic                        zero;
  logic                        s;
  dsas_pkg::s2_t               s2_d;
  dsas_pkg::s2_t               s2_q;
  logic                        valid_q;

  always_comb begin
    for (int k = 0; k < dsas_pkg::DIGITS; k++) begin
      v[k]   = {1'b0, s1_i.x[4*k +: 4]} + {1'b0, s1_i.y[4*k +: 4]};
      gen[k] = v[k] > 5'd9;
      gp[k]  = v[k] >= 5'd9;
    end
  end

  // generate/propagate carries resolved by one binary add
  assign csum = {1'b0, gp} + {1'b0, gen};
  assign cin  = csum[dsas_pkg::DIGITS-1:0] ^ gp ^ gen;
  assign cout = csum[dsas_pkg::DIGITS];

  always_comb begin
    for (int k = 0; k < dsas_pkg::DIGITS; k++) begin
      u = v[k] + {4'd0, cin[k]};
      r[4*k +: 4] = (u >= 5'd10) ? 4'(u - 5'd10) : u[3:0];
    end
  end

  assign zero = ~(|r);
  assign s    = s1_i.sa ^ s1_i.sb ^ cout;

  always_comb begin
    s2_d.r    = r;
    s2_d.neg  = 1'b0;
    s2_d.sign = s1_i.shift_sign;
    s2_d.err  = s1_i.shift_err ? dsas_pkg::ERR_SHIFT : dsas_pkg::ERR_NONE;
    if (s1_i.arith) begin
      s2_d.sign = s;
      if (s && !s1_i.sa && !s1_i.sb) begin
        s2_d.err = dsas_pkg::ERR_POS_OVF;
      end else if (!s && s1_i.sa && s1_i.sb) begin
        s2_d.err = dsas_pkg::ERR_NEG_OVF;
      end else if (s && zero) begin
        s2_d.err = dsas_pkg::ERR_NEG_OVF;
      end else begin
        s2_d.err = dsas_pkg::ERR_NONE;
        s2_d.neg = s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = valid_q;
  assign s2_o    = s2_q;

endmodule

[rtl/dsas_fix.sv]
// third stage: back to magnitude form, error clearing, output register
// depends on dsas_pkg
module dsas_fix (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  dsas_pkg::s2_t     s2_i,
  output logic              valid_o,
  output logic              sign_o,
  output dsas_pkg::digits_t digits_o,
  output logic [1:0]        err_o
);

  dsas_pkg::digits_t digits_d;
  logic              sign_d;
  dsas_pkg::digits_t digits_q;
  logic              sign_q;
  logic [1:0]        err_q;
  logic              valid_q;

  always_comb begin
    if (s2_i.err != dsas_pkg::ERR_NONE) begin
      digits_d = '0;
      sign_d   = 1'b0;
    end else begin
      digits_d = s2_i.neg ? dsas_pkg::tens_comp(s2_i.r) : s2_i.r;
      sign_d   = s2_i.sign;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      digits_q <= digits_d;
      sign_q   <= sign_d;
      err_q    <= s2_i.err;
    end
  end

  assign valid_o  = valid_q;
  assign sign_o   = sign_q;
  assign digits_o = digits_q;
  assign err_o    = err_q;

endmodule

[rtl/dsas_chk.sv]
// port-level checker for the decimal add/sub/shift unit, bound to the top
// depends on dsas_pkg and decimal_signed_add_sub_shift_top_macros.svh
`include "decimal_signed_add_sub_shift_top_macros.svh"

module dsas_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  command_i,
  input logic        result_valid_o,
  input logic        result_sign_o,
  input logic [63:0] result_digits_low_o,
  input logic [63:0] result_digits_mid_o,
  input logic [59:0] result_digits_high_o,
  input logic [1:0]  error_code_o
);

  logic err_seen;
  logic shift_err_seen;
  logic res_clear;

  assign err_seen       = result_valid_o && error_code_o != dsas_pkg::ERR_NONE;
  assign shift_err_seen = result_valid_o && error_code_o == dsas_pkg::ERR_SHIFT;
  assign res_clear      = !result_sign_o && result_digits_low_o == 64'd0 &&
                          result_digits_mid_o == 64'd0 && result_digits_high_o == 60'd0;

  // every request yields its result once it has passed the prep, add and fix registers
  `DSAS_CHECK(a_req_to_result, start && !busy |-> ##3 result_valid_o)

  // no result without an earlier request that has passed the prep, add and fix registers
  `DSAS_CHECK(a_result_has_req, result_valid_o |-> $past(start && !busy, 3))

  // error results carry zero sign and digits
  `DSAS_CHECK(a_err_clears, err_seen |-> res_clear)

  // lost top digit only from multiply by ten
  `DSAS_CHECK(a_shift_err_cmd, shift_err_seen |-> $past(command_i, 3) == dsas_pkg::CMD_MUL10)

endmodule

bind decimal_signed_add_sub_shift_top dsas_chk u_dsas_chk (.*);
